FILE: design/fractional_rate_linear_resampler_assert.svh
// Assertion macros for the fractional-rate linear resampler.
// Included by the top level; no other dependencies.
`ifndef FRACTIONAL_RATE_LINEAR_RESAMPLER_ASSERT_SVH
`define FRACTIONAL_RATE_LINEAR_RESAMPLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRLR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FRLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/frlr_pkg.sv
// Shared types and constants for the fractional-rate linear resampler.
// No dependencies.
package frlr_pkg;

  // Width of the rate and clock registers and of the phase
  localparam int REG_WIDTH = 17;
  typedef logic [REG_WIDTH-1:0] reg_t;

  localparam reg_t RATE_RESET  = 17'd48000;
  localparam reg_t CLOCK_RESET = 17'd110860;
  localparam reg_t CLOCK_MIN   = 17'd2;

  // Configuration register indexes
  typedef enum logic {
    REG_OUTPUT_RATE  = 1'b0,
    REG_SOURCE_CLOCK = 1'b1
  } reg_index_t;

endpackage

FILE: design/frlr_if.sv
// Valid/ready stream interfaces for the resampler's sample channels.
// No dependencies.
interface frlr_in_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface frlr_out_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: design/fractional_rate_linear_resampler.sv
// Fractional-rate linear-interpolation resampler, top level.
// Depends on frlr_pkg, frlr_if.sv and fractional_rate_linear_resampler_assert.svh.
//
// din carries one signed source sample per item; dout carries the interpolated
// samples. An item moves when valid and ready are both high. The config port
// (cfg_wr_en, cfg_index, cfg_data) writes output_rate (index 0) and
// source_clock (index 1); write only while the block is idle.
// Each item adds the output rate to the phase. On a wrap the block forms
// rem*previous + (clock-rem)*current with a shift-add multiplier, takes the
// magnitude and divides by the clock with a restoring divider (one quotient
// bit per cycle).
// An item that does not wrap leaves the block idle and ready for the next
// item; a wrapping item holds din.ready low through the serial multiply and
// divide until its result is loaded into the output register.
// A new item can be accepted while a result waits in the output register.
// If dout stalls, the next result waits in the datapath and din.ready stays low.
// Reset (rst, synchronous) restores the register defaults, clears the
// previous sample and phase, and empties the output.
`include "fractional_rate_linear_resampler_assert.svh"

module fractional_rate_linear_resampler #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  frlr_pkg::reg_index_t   cfg_index,
  input  frlr_pkg::reg_t         cfg_data,
  frlr_in_if.sink                din,
  frlr_out_if.source             dout
);

  localparam int W_WIDTH   = frlr_pkg::REG_WIDTH;
  localparam int ACC_WIDTH = W_WIDTH + SAMPLE_WIDTH + 1;
  localparam int STEPS_MAX = (SAMPLE_WIDTH > W_WIDTH) ? SAMPLE_WIDTH : W_WIDTH;
  localparam int CNT_WIDTH = $clog2(STEPS_MAX);
  localparam logic [CNT_WIDTH-1:0] MUL_LAST = CNT_WIDTH'(W_WIDTH - 1);
  localparam logic [CNT_WIDTH-1:0] DIV_LAST = CNT_WIDTH'(SAMPLE_WIDTH - 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_ABS, ST_DIV, ST_DONE} state_t;

  // Configuration and state registers
  frlr_pkg::reg_t output_rate;
  frlr_pkg::reg_t source_clock;
  sample_t        previous_sample;
  frlr_pkg::reg_t phase_remainder;

  // Sequencer and datapath registers
  state_t                        state;
  logic [CNT_WIDTH-1:0]          count;
  sample_t                       op_prev;
  sample_t                       op_cur;
  frlr_pkg::reg_t                w_prev;
  frlr_pkg::reg_t                w_cur;
  frlr_pkg::reg_t                divisor;
  logic signed [ACC_WIDTH-1:0]   prod;
  logic                          negative;
  frlr_pkg::reg_t                div_rem;
  logic [SAMPLE_WIDTH-1:0]       quot;
  logic                          out_valid;
  sample_t                       out_sample;

  // Phase update logic
  frlr_pkg::reg_t         clk_eff;
  frlr_pkg::reg_t         rate_eff;
  frlr_pkg::reg_t         rem_eff;
  logic [W_WIDTH:0]       phase_sum;
  logic [W_WIDTH:0]       wrap_diff;
  logic                   wrap;
  frlr_pkg::reg_t         rem_wrap;
  logic                   in_fire;

  // Multiplier step
  logic signed [SAMPLE_WIDTH:0]   pick_prev;
  logic signed [SAMPLE_WIDTH:0]   pick_cur;
  logic signed [SAMPLE_WIDTH:0]   addend;
  logic signed [SAMPLE_WIDTH:0]   prod_hi;
  logic signed [SAMPLE_WIDTH+1:0] hi_sum;

  // Magnitude and divider step
  logic [ACC_WIDTH-1:0]   mag;
  logic [W_WIDTH:0]       trial;
  logic [W_WIDTH:0]       trial_diff;
  logic                   fits;

  always_comb begin
    clk_eff   = (source_clock < frlr_pkg::CLOCK_MIN) ? frlr_pkg::CLOCK_MIN : source_clock;
    rate_eff  = (output_rate >= clk_eff) ? clk_eff - 1'b1 : output_rate;
    rem_eff   = (phase_remainder >= clk_eff) ? clk_eff - 1'b1 : phase_remainder;
    phase_sum = {1'b0, rem_eff} + {1'b0, rate_eff};
    wrap      = (phase_sum >= {1'b0, clk_eff});
    wrap_diff = phase_sum - {1'b0, clk_eff};
    rem_wrap  = wrap_diff[W_WIDTH-1:0];
  end

  assign din.ready       = (state == ST_IDLE);
  assign in_fire         = din.valid && din.ready;
  assign dout.valid      = out_valid;
  assign dout.sample_out = out_sample;

  // One weight bit of each product per cycle, accumulated at the top
  always_comb begin
    pick_prev = w_prev[0] ? {op_prev[SAMPLE_WIDTH-1], op_prev} : '0;
    pick_cur  = w_cur[0]  ? {op_cur[SAMPLE_WIDTH-1], op_cur}   : '0;
    addend    = pick_prev + pick_cur;
    prod_hi   = prod[ACC_WIDTH-1:W_WIDTH];
    hi_sum    = {prod_hi[SAMPLE_WIDTH], prod_hi} + {addend[SAMPLE_WIDTH], addend};
  end

  // Magnitude of the weighted sum, then one restoring division step
  always_comb begin
    mag        = prod[ACC_WIDTH-1] ? ACC_WIDTH'(~prod + 1'b1) : ACC_WIDTH'(prod);
    trial      = {div_rem, quot[SAMPLE_WIDTH-1]};
    fits       = (trial >= {1'b0, divisor});
    trial_diff = trial - {1'b0, divisor};
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      output_rate  <= frlr_pkg::RATE_RESET;
      source_clock <= frlr_pkg::CLOCK_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        frlr_pkg::REG_OUTPUT_RATE:  output_rate  <= cfg_data;
        frlr_pkg::REG_SOURCE_CLOCK: source_clock <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      count           <= '0;
      out_valid       <= 1'b0;
      previous_sample <= '0;
      phase_remainder <= '0;
    end else begin
      // Output register empties on accept; the done state reloads it itself
      if (out_valid && dout.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            previous_sample <= din.sample_in;
            op_prev         <= previous_sample;
            op_cur          <= din.sample_in;
            count           <= '0;
            if (wrap) begin
              phase_remainder <= rem_wrap;
              w_prev          <= rem_wrap;
              w_cur           <= clk_eff - rem_wrap;
              divisor         <= clk_eff;
              prod            <= '0;
              state           <= ST_MUL;
            end else begin
              phase_remainder <= phase_sum[W_WIDTH-1:0];
            end
          end
        end
        ST_MUL: begin
          prod   <= {hi_sum, prod[W_WIDTH-1:1]};
          w_prev <= w_prev >> 1;
          w_cur  <= w_cur >> 1;
          count  <= count + 1'b1;
          if (count == MUL_LAST) begin
            state <= ST_ABS;
          end
        end
        ST_ABS: begin
          negative <= prod[ACC_WIDTH-1];
          div_rem  <= mag[ACC_WIDTH-2:SAMPLE_WIDTH];
          quot     <= mag[SAMPLE_WIDTH-1:0];
          count    <= '0;
          state    <= ST_DIV;
        end
        ST_DIV: begin
          div_rem <= fits ? trial_diff[W_WIDTH-1:0] : trial[W_WIDTH-1:0];
          quot    <= {quot[SAMPLE_WIDTH-2:0], fits};
          count   <= count + 1'b1;
          if (count == DIV_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || dout.ready) begin
            out_sample <= negative ? sample_t'(~quot + 1'b1) : sample_t'(quot);
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `FRLR_ASSERT_NEXT(a_phase_below_clock, clk, rst, in_fire,
    phase_remainder < $past(clk_eff), "phase not below clock after item")
  `FRLR_ASSERT_NEXT(a_wrap_starts_mul, clk, rst, in_fire && wrap,
    state == ST_MUL, "phase wrap did not start multiply")
  `FRLR_ASSERT_SAME(a_div_rem_below_divisor, clk, rst, state == ST_DIV || state == ST_DONE,
    div_rem < divisor, "divider remainder out of range")
  `FRLR_ASSERT_NEXT(a_done_waits, clk, rst, state == ST_DONE && out_valid && !dout.ready,
    state == ST_DONE && out_valid, "result overwrote pending output")

endmodule

FILE: sim/tb.sv
// Testbench for the fractional-rate linear resampler.
// Needs frlr_pkg, frlr_if.sv and the resampler top level; checks every output
// sample against a cycle-free model of the phase accumulator and interpolator.
`timescale 1ns / 100ps

module tb;

  localparam int SW            = 16;
  localparam int SETTLE_CYCLES = 40;   // covers a whole interpolation
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int CHUNK_ITEMS   = 50;

  typedef logic signed [SW-1:0] sample_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  frlr_pkg::reg_index_t cfg_index;
  frlr_pkg::reg_t       cfg_data;

  frlr_in_if  #(.SAMPLE_WIDTH(SW)) din_if ();
  frlr_out_if #(.SAMPLE_WIDTH(SW)) dout_if ();

  fractional_rate_linear_resampler #(.SAMPLE_WIDTH(SW)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (din_if),
    .dout      (dout_if)
  );

  // Model state
  frlr_pkg::reg_t rate_q;
  frlr_pkg::reg_t clock_q;
  frlr_pkg::reg_t phase_q;
  sample_t        prev_q;
  sample_t        expected_samples[$];

  int fail_count    = 0;
  int stall_count   = 0;
  int in_idle_pct   = 0;
  int out_idle_pct  = 0;
  int hold_requests = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Phase accumulate and, on wrap, interpolate between previous and current
  function automatic void advance_phase(input sample_t cur);
    logic [17:0] modulus;
    logic [17:0] step;
    logic [17:0] phase;
    logic [17:0] total;
    longint weighted;
    modulus = (clock_q < frlr_pkg::CLOCK_MIN) ? 18'(frlr_pkg::CLOCK_MIN) : 18'(clock_q);
    step    = (rate_q >= modulus) ? modulus - 18'd1 : 18'(rate_q);
    phase   = (phase_q >= modulus) ? modulus - 18'd1 : 18'(phase_q);
    total   = phase + step;
    if (total >= modulus) begin
      phase    = total - modulus;
      weighted = longint'(phase) * longint'(prev_q)
               + longint'(modulus - phase) * longint'(cur);
      expected_samples.push_back(sample_t'(weighted / longint'(modulus)));
    end else begin
      phase = total;
    end
    phase_q = frlr_pkg::reg_t'(phase);
    prev_q  = cur;
  endfunction

  // Model update, output check and stall watchdog
  always @(posedge clk) begin
    sample_t want;
    if (rst) begin
      rate_q      = frlr_pkg::RATE_RESET;
      clock_q     = frlr_pkg::CLOCK_RESET;
      phase_q     = '0;
      prev_q      = '0;
      stall_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          frlr_pkg::REG_OUTPUT_RATE:  rate_q  = cfg_data;
          frlr_pkg::REG_SOURCE_CLOCK: clock_q = cfg_data;
        endcase
      end
      if (din_if.valid && din_if.ready) advance_phase(din_if.sample_in);
      if (dout_if.valid && dout_if.ready) begin
        if (expected_samples.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected output item: sample_out %0d", dout_if.sample_out);
        end else begin
          want = expected_samples.pop_front();
          if (dout_if.sample_out !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("sample_out mismatch: expected %0d, got %0d",
                       want, dout_if.sample_out);
          end
        end
      end
      if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready))
        stall_count = 0;
      else
        stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("no item moved for %0d cycles", STALL_LIMIT);
        $display("** fractional_rate_linear_resampler: FAILED **");
        $finish;
      end
    end
  end

  // Output side: random back-pressure, plus long holds on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    dout_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        dout_if.ready <= 1'b0;
      end else begin
        dout_if.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Offer one sample; returns at the edge where it is accepted
  task automatic send_sample(input sample_t value);
    while ($urandom_range(99) < in_idle_pct) begin
      din_if.valid <= 1'b0;
      @(posedge clk);
    end
    din_if.valid     <= 1'b1;
    din_if.sample_in <= value;
    do @(posedge clk); while (!din_if.ready);
  endtask

  // Stop offering and let all outstanding outputs come back
  task automatic drain();
    din_if.valid <= 1'b0;
    // let the model see the last accepted item first
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input frlr_pkg::reg_t rate, input frlr_pkg::reg_t clock);
    cfg_wr_en <= 1'b1;
    cfg_index <= frlr_pkg::REG_OUTPUT_RATE;
    cfg_data  <= rate;
    @(posedge clk);
    cfg_index <= frlr_pkg::REG_SOURCE_CLOCK;
    cfg_data  <= clock;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0:       return sample_t'(32767);
      1:       return sample_t'(-32768);
      2:       return sample_t'(int'($urandom_range(15)) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Reset values of the registers, sample extremes
  task automatic test_reset_defaults();
    send_sample(sample_t'(32767));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(0));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(32767));
    send_sample(sample_t'(1));
    drain();
  endtask

  // Phase left above a newly lowered clock gets saturated
  task automatic test_stale_phase();
    write_config(frlr_pkg::reg_t'(50), frlr_pkg::reg_t'(100));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(12345));
    drain();
  endtask

  // Source clock of zero and of one both act as two
  task automatic test_clock_floor();
    write_config(frlr_pkg::reg_t'(131071), frlr_pkg::reg_t'(0));
    send_sample(sample_t'(32767));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(32767));
    send_sample(sample_t'(-2));
    drain();
    write_config(frlr_pkg::reg_t'(5), frlr_pkg::reg_t'(1));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(32767));
    send_sample(sample_t'(7));
    drain();
  endtask

  // Rate at the clock saturates to clock - 1, largest weights
  task automatic test_rate_saturation();
    write_config(frlr_pkg::reg_t'(131071), frlr_pkg::reg_t'(131071));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(-32768));
    send_sample(sample_t'(32767));
    send_sample(sample_t'(32767));
    drain();
  endtask

  // Zero rate: phase never advances, no output ever
  task automatic test_zero_rate();
    write_config(frlr_pkg::reg_t'(0), frlr_pkg::reg_t'(1000));
    repeat (4) send_sample(random_sample());
    drain();
  endtask

  // Random samples under random settings, reconfigured every chunk
  task automatic test_random_traffic(input int count, input int in_pct, input int out_pct);
    frlr_pkg::reg_t rate;
    frlr_pkg::reg_t clock;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    for (int i = 0; i < count; i++) begin
      if (i % CHUNK_ITEMS == 0) begin
        drain();
        case ($urandom_range(9))
          0:       clock = frlr_pkg::reg_t'($urandom_range(1));
          1, 2:    clock = frlr_pkg::reg_t'($urandom_range(40, 2));
          3:       clock = frlr_pkg::reg_t'(131071);
          default: clock = frlr_pkg::reg_t'($urandom_range(131071, 2));
        endcase
        case ($urandom_range(19))
          0:       rate = '0;
          1, 2:    rate = frlr_pkg::reg_t'($urandom);
          3:       rate = frlr_pkg::reg_t'(131071);
          default: rate = frlr_pkg::reg_t'($urandom_range(clock, clock / 4));
        endcase
        write_config(rate, clock);
      end
      send_sample(random_sample());
    end
    drain();
  endtask

  // Long output hold while inputs keep coming: the block must fill and stall
  task automatic test_backpressure();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    write_config(frlr_pkg::reg_t'(131070), frlr_pkg::reg_t'(131071));
    hold_requests++;
    repeat (24) send_sample(random_sample());
    drain();
  endtask

  initial begin
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_index        = frlr_pkg::REG_OUTPUT_RATE;
    cfg_data         = '0;
    din_if.valid     = 1'b0;
    din_if.sample_in = '0;
    in_idle_pct      = 36;
    out_idle_pct     = 49;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_stale_phase();
    test_clock_floor();
    test_rate_saturation();
    test_zero_rate();
    test_random_traffic(330, 36, 49);
    test_random_traffic(330, 49, 36);
    test_random_traffic(340, 0, 0);
    test_backpressure();

    if (fail_count == 0)
      $display("** fractional_rate_linear_resampler: PASSED **");
    else
      $display("** fractional_rate_linear_resampler: FAILED **");
    $finish;
  end

endmodule
